[design/pcpq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the pedal control panel qualifier.
// No dependencies; imported by every module of the block.
package pcpq_pkg;

   // Number of effect slots selectable by the knob in set mode.
   localparam int SLOT_COUNT = 4;
   localparam int SLOT_W = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;

   localparam int SAMPLE_W = 12;
   localparam int KNOB_W = 17;
   localparam int ZONE_W = 14;
   localparam logic [KNOB_W-1:0] KNOB_FULL = 17'd65536;
   localparam logic [ZONE_W-1:0] KNOB_ZONE_RESET = 14'd983;

   // Panel modes, from the inverted toggle pins.
   localparam logic [1:0] MODE_SET = 2'd0;
   localparam logic [1:0] MODE_MOMENTARY = 2'd1;
   localparam logic [1:0] MODE_LATCH = 2'd2;

   typedef enum logic [1:0] {
      EVENT_NONE = 2'd0,
      EVENT_PARAM = 2'd1,
      EVENT_SLOT = 2'd2
   } event_kind_type;

   // Scaled knob and the slot it points at.
   typedef struct packed {
      logic [KNOB_W-1:0] value;
      logic [SLOT_W-1:0] slot;
   } pcpq_knob_type;

   // One result item.
   typedef struct packed {
      logic effect_on;
      logic [1:0] panel_mode;
      logic [1:0] current_slot;
      event_kind_type event_kind;
      logic [KNOB_W-1:0] knob_value;
   } pcpq_result_type;

endpackage

[design/pcpq_scale.sv]
`timescale 1ns / 1ps
// Knob scaling: raw 12-bit sample to Q16 position, plus the slot it selects.
// Depends on pcpq_pkg.
module pcpq_scale import pcpq_pkg::*; (
   input  logic [SAMPLE_W-1:0] sample,
   output pcpq_knob_type       knob
);

   // k = floor((1648*s - 98304) / 100) = floor((412*s - 24576) / 25)
   localparam int NUM_W = 21;
   localparam int RECIP_W = 26;
   localparam int RECIP_SHIFT = 30;
   localparam int PROD_W = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP25 = 26'd42949673; // ceil(2^30 / 25)
   localparam logic [NUM_W-1:0] KNOB_GAIN = 21'd412;
   localparam logic [NUM_W-1:0] KNOB_OFFSET = 21'd24576;

   localparam int SPROD_W = KNOB_W + $clog2(SLOT_COUNT + 1);
   localparam int SRAW_W = SPROD_W - 16;

   logic [NUM_W-1:0] scaled;
   logic [NUM_W-1:0] shifted;
   logic [PROD_W-1:0] prod;
   logic [KNOB_W-1:0] quot;
   logic [KNOB_W-1:0] value;
   logic [SPROD_W-1:0] slot_prod;
   logic [SRAW_W-1:0] slot_raw;

   always_comb begin
      scaled = NUM_W'(sample) * KNOB_GAIN;
      shifted = scaled - KNOB_OFFSET;
      // exact for shifted < 2^30/25
      prod = PROD_W'(shifted) * PROD_W'(RECIP25);
      quot = prod[RECIP_SHIFT +: KNOB_W];
      if (scaled < KNOB_OFFSET) begin
         value = '0;
      end else if (quot > KNOB_FULL) begin
         value = KNOB_FULL;
      end else begin
         value = quot;
      end

      slot_prod = SPROD_W'(value) * SPROD_W'(SLOT_COUNT);
      slot_raw = slot_prod[SPROD_W-1:16];
      knob.value = value;
      if (slot_raw >= SRAW_W'(SLOT_COUNT)) begin
         knob.slot = SLOT_W'(SLOT_COUNT - 1);
      end else begin
         knob.slot = SLOT_W'(slot_raw);
      end
   end

endmodule

[design/pcpq_state.sv]
`timescale 1ns / 1ps
// Panel state: mode, effect enable, foot edge, knob dead zone and slot.
// Depends on pcpq_pkg.
module pcpq_state import pcpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  logic              toggle_one_pin,
   input  logic              toggle_two_pin,
   input  logic              foot_pin,
   input  pcpq_knob_type     knob,
   input  logic [ZONE_W-1:0] knob_zone,
   output pcpq_result_type   result
);

   logic [1:0] mode_ff, mode_in;
   logic enable_ff, enable_in;
   logic wide_ff, wide_in;
   logic foot_last_ff, foot_last_in;
   logic [KNOB_W-1:0] knob_last_ff, knob_last_in;
   logic primed_ff, primed_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [ZONE_W+1:0] zone;
   logic [KNOB_W-1:0] knob_delta;
   logic act;
   event_kind_type event_kind;

   always_comb begin
      mode_in = {~toggle_two_pin, ~toggle_one_pin};
      enable_in = enable_ff;
      wide_in = wide_ff;
      foot_last_in = foot_last_ff;
      knob_last_in = knob_last_ff;
      primed_in = primed_ff;
      slot_in = slot_ff;
      event_kind = EVENT_NONE;

      if (mode_in != mode_ff) begin
         enable_in = 1'b0;
         wide_in = 1'b1;
      end

      if (foot_pin != foot_last_ff) begin
         foot_last_in = foot_pin;
         if (mode_in == MODE_LATCH && foot_pin) begin
            enable_in = ~enable_in;
         end else if (mode_in == MODE_MOMENTARY) begin
            enable_in = foot_pin;
         end
      end

      zone = wide_in ? {knob_zone, 2'b00} : {2'b00, knob_zone};
      knob_delta = (knob.value > knob_last_ff) ? knob.value - knob_last_ff
                                               : knob_last_ff - knob.value;
      act = (knob.value == KNOB_FULL && knob_last_ff != KNOB_FULL)
         || (knob.value == '0 && knob_last_ff != '0)
         || (knob_delta >= KNOB_W'(zone));

      if (!primed_ff) begin
         primed_in = 1'b1;
         knob_last_in = knob.value;
      end else if (act) begin
         wide_in = 1'b0;
         knob_last_in = knob.value;
         if (mode_in != MODE_SET) begin
            event_kind = EVENT_PARAM;
         end else if (knob.slot != slot_ff) begin
            slot_in = knob.slot;
            event_kind = EVENT_SLOT;
         end
      end

      result.effect_on = enable_in;
      result.panel_mode = mode_in;
      result.current_slot = 2'(slot_in);
      result.event_kind = event_kind;
      result.knob_value = knob.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SET;
         enable_ff <= 1'b0;
         wide_ff <= 1'b0;
         foot_last_ff <= 1'b0;
         knob_last_ff <= '0;
         primed_ff <= 1'b0;
         slot_ff <= '0;
      end else if (update) begin
         mode_ff <= mode_in;
         enable_ff <= enable_in;
         wide_ff <= wide_in;
         foot_last_ff <= foot_last_in;
         knob_last_ff <= knob_last_in;
         primed_ff <= primed_in;
         slot_ff <= slot_in;
      end
   end

endmodule

[design/pedal_control_panel_qualifier.sv]
`timescale 1ns / 1ps
// Top level of the pedal control panel qualifier.
// Depends on pcpq_pkg, pcpq_scale and pcpq_state.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_valid / req_stall  | toggle pins, foot pin, knob
//  rsp     | out       | rsp_valid / rsp_stall  | enable, mode, slot, event, knob
//  csr     | in        | csr_write_enable       | dead zone, written at once
//
// One item per cycle sustained while rsp_stall is low; each item passes through
// the input register and the result register, in that order. Knob scaling (one
// reciprocal multiply) and the state update sit between those two registers.
// Synchronous active-high reset clears all but payload; dead zone returns to 983.
// A stalled result holds; the input register keeps taking transfers while
// it empties into the result register, so req_stall rises only when both
// are full and rsp_stall is high.
module pedal_control_panel_qualifier import pcpq_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_toggle_one_pin,
   input  logic                req_toggle_two_pin,
   input  logic                req_foot_pin,
   input  logic [SAMPLE_W-1:0] req_knob_sample,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_effect_on,
   output logic [1:0]          rsp_panel_mode,
   output logic [1:0]          rsp_current_slot,
   output logic [1:0]          rsp_event_kind,
   output logic [KNOB_W-1:0]   rsp_knob_value,

   input  logic                csr_write_enable,
   input  logic [ZONE_W-1:0]   csr_write_data
);

   // input register
   logic in_valid_ff, in_valid_in;
   logic tog_one_ff, tog_two_ff, foot_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   // result register
   logic out_valid_ff, out_valid_in;
   pcpq_result_type result_ff;
   pcpq_result_type result_next;

   logic [ZONE_W-1:0] knob_zone_ff;
   pcpq_knob_type knob;
   logic advance;
   logic take;

   // The result register can load whenever it is empty or being drained.
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   pcpq_scale u_scale (
      .sample (sample_ff),
      .knob   (knob)
   );

   // State commits as the item moves into the result register.
   pcpq_state u_state (
      .clock          (clock),
      .reset          (reset),
      .update         (in_valid_ff && advance),
      .toggle_one_pin (tog_one_ff),
      .toggle_two_pin (tog_two_ff),
      .foot_pin       (foot_ff),
      .knob           (knob),
      .knob_zone      (knob_zone_ff),
      .result         (result_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         knob_zone_ff <= KNOB_ZONE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            knob_zone_ff <= csr_write_data;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         tog_one_ff <= req_toggle_one_pin;
         tog_two_ff <= req_toggle_two_pin;
         foot_ff <= req_foot_pin;
         sample_ff <= req_knob_sample;
      end
      if (in_valid_ff && advance) begin
         result_ff <= result_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_effect_on = result_ff.effect_on;
   assign rsp_panel_mode = result_ff.panel_mode;
   assign rsp_current_slot = result_ff.current_slot;
   assign rsp_event_kind = result_ff.event_kind;
   assign rsp_knob_value = result_ff.knob_value;

endmodule
